// ----- hdl/scsa_pkg.sv -----
package scsa_pkg;

  // Pool geometry
  localparam int NUM_CHUNKS   = 64;
  localparam int CHUNK_BYTES  = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int NUM_CLASSES  = 5;
  localparam int SLICE_SLOTS  = 128;

  localparam int CHUNK_W  = 6;
  localparam int SLICE_W  = 7;
  localparam int HANDLE_W = CHUNK_W + SLICE_W;
  localparam int CNT_W    = 14;
  localparam int CLAIM_W  = 7;
  localparam int CLS_W    = 3;
  localparam int SPC_W    = 8;
  localparam int TOTAL_W  = 9;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Slice bytes per class
  localparam int CLS_BYTES_0 = 32;
  localparam int CLS_BYTES_1 = 64;
  localparam int CLS_BYTES_2 = 96;
  localparam int CLS_BYTES_3 = 128;
  localparam int CLS_BYTES_4 = 256;

  // Slices per chunk, capped at the slot count
  localparam int SPC_0 = (CHUNK_BYTES / CLS_BYTES_0 > SLICE_SLOTS) ? SLICE_SLOTS
                                                                    : CHUNK_BYTES / CLS_BYTES_0;
  localparam int SPC_1 = (CHUNK_BYTES / CLS_BYTES_1 > SLICE_SLOTS) ? SLICE_SLOTS
                                                                    : CHUNK_BYTES / CLS_BYTES_1;
  localparam int SPC_2 = (CHUNK_BYTES / CLS_BYTES_2 > SLICE_SLOTS) ? SLICE_SLOTS
                                                                    : CHUNK_BYTES / CLS_BYTES_2;
  localparam int SPC_3 = (CHUNK_BYTES / CLS_BYTES_3 > SLICE_SLOTS) ? SLICE_SLOTS
                                                                    : CHUNK_BYTES / CLS_BYTES_3;
  localparam int SPC_4 = (CHUNK_BYTES / CLS_BYTES_4 > SLICE_SLOTS) ? SLICE_SLOTS
                                                                    : CHUNK_BYTES / CLS_BYTES_4;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_CHUNK   = 2'd1,
    ST_TOO_LARGE  = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic               too_large;
    logic [CLS_W-1:0]   cls;
  } cls_dec_t;

  typedef struct packed {
    status_t              status;
    logic [CHUNK_W-1:0]   got_chunk;
    logic [SLICE_W-1:0]   got_slice;
    logic [CLS_W-1:0]     size_class;
    logic [CNT_W-1:0]     live_objects;
    logic [CLAIM_W-1:0]   chunks_in_use;
  } res_t;

  // Link memory port: entry holds valid bit plus handle
  typedef struct packed {
    logic                 rd_en;
    logic [HANDLE_W-1:0]  rd_addr;
    logic                 wr_en;
    logic [HANDLE_W-1:0]  wr_addr;
    logic [HANDLE_W:0]    wr_data;
  } link_port_t;

  // Chunk class memory port
  typedef struct packed {
    logic                 rd_en;
    logic [CHUNK_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [CHUNK_W-1:0]   wr_addr;
    logic [CLS_W-1:0]     wr_data;
  } cls_port_t;

  function automatic logic [SPC_W-1:0] slices_in_chunk(input logic [CLS_W-1:0] cls);
    logic [SPC_W-1:0] n;
    unique case (cls)
      3'd0:    n = SPC_W'(SPC_0);
      3'd1:    n = SPC_W'(SPC_1);
      3'd2:    n = SPC_W'(SPC_2);
      3'd3:    n = SPC_W'(SPC_3);
      default: n = SPC_W'(SPC_4);
    endcase
    return n;
  endfunction

  // Round up to 8, add the header and pick the smallest class that fits, else flag too large
  function automatic cls_dec_t decode_size(input logic [7:0] sz);
    logic [TOTAL_W-1:0] rnd;
    logic [TOTAL_W-1:0] total;
    cls_dec_t           d;
    rnd   = ({1'b0, sz} + TOTAL_W'(7)) & ~TOTAL_W'(7);
    total = rnd + TOTAL_W'(HEADER_BYTES);
    d.too_large = 1'b0;
    if (total <= TOTAL_W'(CLS_BYTES_0)) begin
      d.cls = 3'd0;
    end else if (total <= TOTAL_W'(CLS_BYTES_1)) begin
      d.cls = 3'd1;
    end else if (total <= TOTAL_W'(CLS_BYTES_2)) begin
      d.cls = 3'd2;
    end else if (total <= TOTAL_W'(CLS_BYTES_3)) begin
      d.cls = 3'd3;
    end else if (total <= TOTAL_W'(CLS_BYTES_4)) begin
      d.cls = 3'd4;
    end else begin
      d.cls       = 3'd0;
      d.too_large = 1'b1;
    end
    return d;
  endfunction

endpackage

// ----- hdl/scsa_ram.sv -----
module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/scsa_ctrl.sv -----
module scsa_ctrl
  import scsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CLAIM_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  req_type_t            in_type,
  input  logic [7:0]           in_size,
  input  logic [CHUNK_W-1:0]   in_chunk,
  input  logic [SLICE_W-1:0]   in_slice,
  input  logic                 out_free,
  output logic                 res_valid,
  output res_t                 res,
  output link_port_t           link_port,
  input  logic [HANDLE_W:0]    link_rdata,
  output cls_port_t            cls_port,
  input  logic [CLS_W-1:0]     cls_rdata
);

  state_t state, state_next;

  logic [CLAIM_W-1:0]  chunk_limit;
  logic [CLAIM_W-1:0]  claimed, claimed_next;
  logic [CNT_W-1:0]    obj_cnt, obj_cnt_next;

  logic                head_vld      [NUM_CLASSES];
  logic [HANDLE_W-1:0] head_h        [NUM_CLASSES];
  logic                cur_vld       [NUM_CLASSES];
  logic [HANDLE_W-1:0] cur_h         [NUM_CLASSES];
  logic                head_vld_next [NUM_CLASSES];
  logic [HANDLE_W-1:0] head_h_next   [NUM_CLASSES];
  logic                cur_vld_next  [NUM_CLASSES];
  logic [HANDLE_W-1:0] cur_h_next    [NUM_CLASSES];

  req_type_t           req_type;
  logic [CLS_W-1:0]    req_cls;
  logic                req_big;
  logic [CHUNK_W-1:0]  req_fc;
  logic [SLICE_W-1:0]  req_fs;

  cls_dec_t            in_dec;
  logic                in_fire;
  logic                commit;
  logic [CLAIM_W-1:0]  lim;
  logic [CLS_W-1:0]    fcls;
  logic [SPC_W-1:0]    spc;
  logic [HANDLE_W-1:0] got_h;
  logic                got;
  logic [HANDLE_W-1:0] free_h;

  assign in_dec  = decode_size(in_size);
  assign in_fire = in_valid && in_ready;
  assign commit  = (state == S_EXEC) && out_free;
  assign lim     = (chunk_limit > CLAIM_W'(NUM_CHUNKS)) ? CLAIM_W'(NUM_CHUNKS) : chunk_limit;
  assign fcls    = (cls_rdata >= CLS_W'(NUM_CLASSES)) ? cls_rdata - CLS_W'(NUM_CLASSES)
                                                      : cls_rdata;
  assign free_h  = {req_fc, req_fs};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      S_IDLE:  in_ready  = 1'b1;
      S_EXEC:  res_valid = out_free;
      default: in_ready  = 1'b0;
    endcase
  end

  // Issue memory reads on take; pop, step a cursor, claim a chunk or push; build the result
  always_comb begin
    link_port.rd_en   = in_fire;
    link_port.rd_addr = head_h[in_dec.cls];
    cls_port.rd_en    = in_fire;
    cls_port.rd_addr  = in_chunk;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      head_vld_next[i] = head_vld[i];
      head_h_next[i]   = head_h[i];
      cur_vld_next[i]  = cur_vld[i];
      cur_h_next[i]    = cur_h[i];
    end
    claimed_next       = claimed;
    obj_cnt_next       = obj_cnt;
    got                = 1'b0;
    got_h              = '0;
    spc                = slices_in_chunk(req_cls);
    link_port.wr_en    = 1'b0;
    link_port.wr_addr  = free_h;
    link_port.wr_data  = {head_vld[fcls], head_h[fcls]};
    cls_port.wr_en     = 1'b0;
    cls_port.wr_addr   = claimed[CHUNK_W-1:0];
    cls_port.wr_data   = req_cls;
    res.status         = ST_OK;
    res.size_class     = '0;

    if (req_type == REQ_ALLOC) begin
      if (req_big) begin
        res.status = ST_TOO_LARGE;
      end else begin
        res.size_class = req_cls;
        if (head_vld[req_cls]) begin
          got                    = 1'b1;
          got_h                  = head_h[req_cls];
          head_vld_next[req_cls] = link_rdata[HANDLE_W];
          head_h_next[req_cls]   = link_rdata[HANDLE_W-1:0];
        end else if (cur_vld[req_cls]) begin
          got                   = 1'b1;
          got_h                 = cur_h[req_cls];
          cur_vld_next[req_cls] = ({1'b0, cur_h[req_cls][SLICE_W-1:0]} + SPC_W'(1)) < spc;
          cur_h_next[req_cls]   = cur_h[req_cls] + HANDLE_W'(1);
        end else if (claimed < lim) begin
          got                   = 1'b1;
          got_h                 = {claimed[CHUNK_W-1:0], SLICE_W'(0)};
          cls_port.wr_en        = commit;
          claimed_next          = claimed + CLAIM_W'(1);
          cur_vld_next[req_cls] = spc > SPC_W'(1);
          cur_h_next[req_cls]   = {claimed[CHUNK_W-1:0], SLICE_W'(1)};
        end else begin
          res.status = ST_NO_CHUNK;
        end
        if (got && obj_cnt != COUNT_MAX) begin
          obj_cnt_next = obj_cnt + CNT_W'(1);
        end
      end
    end else begin
      spc = slices_in_chunk(fcls);
      if ({1'b0, req_fc} >= claimed) begin
        res.status = ST_BAD_HANDLE;
      end else if ({1'b0, req_fs} >= spc) begin
        res.status = ST_BAD_HANDLE;
      end else begin
        link_port.wr_en     = commit;
        head_vld_next[fcls] = 1'b1;
        head_h_next[fcls]   = free_h;
        res.size_class      = fcls;
        if (obj_cnt != '0) begin
          obj_cnt_next = obj_cnt - CNT_W'(1);
        end
      end
    end

    res.got_chunk     = got_h[HANDLE_W-1:SLICE_W];
    res.got_slice     = got_h[SLICE_W-1:0];
    res.live_objects  = obj_cnt_next;
    res.chunks_in_use = claimed_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      chunk_limit <= CLAIM_W'(64);
      claimed     <= '0;
      obj_cnt     <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_vld[i] <= 1'b0;
        cur_vld[i]  <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        chunk_limit <= cfg_wdata;
      end
      if (commit) begin
        claimed <= claimed_next;
        obj_cnt <= obj_cnt_next;
        for (int i = 0; i < NUM_CLASSES; i++) begin
          head_vld[i] <= head_vld_next[i];
          cur_vld[i]  <= cur_vld_next[i];
        end
      end
    end
  end

  // List pointers and the held request
  always_ff @(posedge clk) begin
    if (commit) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_h[i] <= head_h_next[i];
        cur_h[i]  <= cur_h_next[i];
      end
    end
    if (in_fire) begin
      req_type <= in_type;
      req_cls  <= in_dec.cls;
      req_big  <= in_dec.too_large;
      req_fc   <= in_chunk;
      req_fs   <= in_slice;
    end
  end

  // Checks
  a_res_only_exec: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> state == S_EXEC)
    else $error("result offered outside execute state");

  a_take_then_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_EXEC && !in_ready)
    else $error("taken item did not move to execute");

  a_claim_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && claimed != $past(claimed)) |->
      (claimed == $past(claimed) + CLAIM_W'(1) && claimed <= CLAIM_W'(NUM_CHUNKS)))
    else $error("chunk claim count moved by other than one or passed the pool");

endmodule

// ----- hdl/size_class_slab_allocator_unit.sv -----
// An item taken is held in execute until the output is free; its result is then loaded
//   into the output register, so a stalled output holds the item in execute until taken.
// A new item is taken only after the last leaves execute, as the read of the link memory
//   at the list head must return before the pop can update that head.
// Reset (rst, synchronous): lists and cursors empty, counters zero, chunk_limit 64.
//   The link and class memories are not cleared; no clearing pass is run.
module size_class_slab_allocator_unit
  import scsa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,       // chunk_limit
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,    // req_size[7:0], free_chunk[13:8], free_slice[20:14]
  input  logic [0:0]   s_axis_tuser,    // req_type[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,    // got_chunk[5:0], got_slice[12:6], size_class[15:13],
                                        // live_objects[29:16], chunks_in_use[36:30]
  output logic [1:0]   m_axis_tuser     // status[1:0]
);

  link_port_t          link_port;
  cls_port_t           cls_port;
  logic [HANDLE_W:0]   link_rdata;
  logic [CLS_W-1:0]    cls_rdata;
  logic                out_free;
  logic                res_valid;
  res_t                res;
  res_t                out_res;
  logic                out_vld;

  assign out_free = !out_vld || m_axis_tready;

  scsa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_type    (req_type_t'(s_axis_tuser[0])),
    .in_size    (s_axis_tdata[7:0]),
    .in_chunk   (s_axis_tdata[13:8]),
    .in_slice   (s_axis_tdata[20:14]),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .link_port  (link_port),
    .link_rdata (link_rdata),
    .cls_port   (cls_port),
    .cls_rdata  (cls_rdata)
  );

  // Next-link store: valid bit plus handle per slice
  scsa_ram #(
    .WIDTH (HANDLE_W + 1),
    .DEPTH (NUM_CHUNKS * SLICE_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_port.wr_en),
    .waddr (link_port.wr_addr),
    .wdata (link_port.wr_data),
    .re    (link_port.rd_en),
    .raddr (link_port.rd_addr),
    .rdata (link_rdata)
  );

  // Class of each claimed chunk
  scsa_ram #(
    .WIDTH (CLS_W),
    .DEPTH (NUM_CHUNKS)
  ) u_cls_ram (
    .clk   (clk),
    .we    (cls_port.wr_en),
    .waddr (cls_port.wr_addr),
    .wdata (cls_port.wr_data),
    .re    (cls_port.rd_en),
    .raddr (cls_port.rd_addr),
    .rdata (cls_rdata)
  );

  // Output register: load a fresh result, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (res_valid) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {3'b000, out_res.chunks_in_use, out_res.live_objects,
                          out_res.size_class, out_res.got_slice, out_res.got_chunk};

endmodule
